### hw/rtl/gdq_pkg.sv
// ----------------------------------------------------------------------------
// gdq_pkg
// shared widths, stage payload types and calendar tables for the
// gregorian date query pipeline
// ----------------------------------------------------------------------------
package gdq_pkg;

   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int WDAY_W    = 3;
   localparam int TOYEAR_W  = 9;
   localparam int YY_W      = 15;
   localparam int SUM_W     = 15;
   localparam int Q100Y_W   = 8;
   localparam int Q100YY_W  = 9;
   localparam int Q7_W      = 13;

   // divide by constant through reciprocal multiply
   localparam int RECIP100_W = 13;
   localparam logic [RECIP100_W-1:0] RECIP_100 = 13'd5243;
   localparam int SHIFT_100 = 19;
   localparam int PROD_Y_W  = YEAR_W + RECIP100_W;
   localparam int PROD_YY_W = YY_W + RECIP100_W;

   localparam int RECIP7_W = 15;
   localparam logic [RECIP7_W-1:0] RECIP_7 = 15'd18725;
   localparam int SHIFT_7 = 17;
   localparam int PROD_S_W = SUM_W + RECIP7_W;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [YY_W-1:0]     yy;
      logic [Q100Y_W-1:0]  qy;
      logic [Q100YY_W-1:0] qyy;
   } s1_type;

   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic                leap;
      logic                invalid;
      logic [DAY_W-1:0]    to_month;
      logic [TOYEAR_W-1:0] to_year;
   } s2_type;

   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [Q7_W-1:0]     q7;
      logic                leap;
      logic                invalid;
      logic [DAY_W-1:0]    to_month;
      logic [TOYEAR_W-1:0] to_year;
   } s3_type;

   typedef struct packed {
      logic                date_invalid;
      logic                leap_year;
      logic [TOYEAR_W-1:0] days_to_year_end;
      logic [DAY_W-1:0]    days_to_month_end;
      logic [WDAY_W-1:0]   days_to_week_end;
      logic                is_week_last_day;
      logic                is_weekend;
      logic [WDAY_W-1:0]   weekday;
   } res_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd2:                               len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:            len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         default:                            len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the months before this one, common year
   function automatic logic [TOYEAR_W-1:0] days_before(input logic [MONTH_W-1:0] month);
      logic [TOYEAR_W-1:0] n;
      case (month)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   // floor(31 * shifted month / 12)
   function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] n;
      case (month)
         4'd1:    n = 5'd28;
         4'd2:    n = 5'd31;
         4'd3:    n = 5'd2;
         4'd4:    n = 5'd5;
         4'd5:    n = 5'd7;
         4'd6:    n = 5'd10;
         4'd7:    n = 5'd12;
         4'd8:    n = 5'd15;
         4'd9:    n = 5'd18;
         4'd10:   n = 5'd20;
         4'd11:   n = 5'd23;
         4'd12:   n = 5'd25;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

### hw/rtl/gdq_prep.sv
// ----------------------------------------------------------------------------
// gdq_prep
// first stage: shifted year and reciprocal multiplies for the divide by 100
// ----------------------------------------------------------------------------
module gdq_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [gdq_pkg::YEAR_W-1:0]    year,
   input  logic [gdq_pkg::MONTH_W-1:0]   month,
   input  logic [gdq_pkg::DAY_W-1:0]     day,
   output logic                          out_valid,
   input  logic                          out_ready,
   output gdq_pkg::s1_type               out_data
);

   logic                               valid_ff;
   gdq_pkg::s1_type                    data_ff;
   gdq_pkg::s1_type                    data_in;
   logic [gdq_pkg::YY_W-1:0]           yy;
   logic [gdq_pkg::PROD_Y_W-1:0]       prod_y;
   logic [gdq_pkg::PROD_YY_W-1:0]      prod_yy;

   assign in_ready = !valid_ff || out_ready;

   // january and february count with the previous year, plus one 400 year cycle
   assign yy = gdq_pkg::YY_W'(year) + gdq_pkg::YY_W'(400)
             - gdq_pkg::YY_W'(month <= gdq_pkg::MONTH_FEB);

   assign prod_y  = gdq_pkg::PROD_Y_W'(year) * gdq_pkg::PROD_Y_W'(gdq_pkg::RECIP_100);
   assign prod_yy = gdq_pkg::PROD_YY_W'(yy) * gdq_pkg::PROD_YY_W'(gdq_pkg::RECIP_100);

   always_comb begin
      data_in       = data_ff;
      data_in.year  = year;
      data_in.month = month;
      data_in.day   = day;
      data_in.yy    = yy;
      data_in.qy    = prod_y[gdq_pkg::SHIFT_100 +: gdq_pkg::Q100Y_W];
      data_in.qyy   = prod_yy[gdq_pkg::SHIFT_100 +: gdq_pkg::Q100YY_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hw/rtl/gdq_cal.sv
// ----------------------------------------------------------------------------
// gdq_cal
// second stage: leap year, range check, month and year end counts and the
// weekday sum before reduction mod 7
// ----------------------------------------------------------------------------
module gdq_cal (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gdq_pkg::s1_type      in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gdq_pkg::s2_type      out_data
);

   logic                               valid_ff;
   gdq_pkg::s2_type                    data_ff;
   gdq_pkg::s2_type                    data_in;
   logic [gdq_pkg::YEAR_W-1:0]         hund_y;
   logic                               leap;
   logic [gdq_pkg::DAY_W-1:0]          mlen;
   logic                               invalid;
   logic [gdq_pkg::TOYEAR_W-1:0]       doy;
   logic [gdq_pkg::TOYEAR_W-1:0]       ylen;
   logic [gdq_pkg::SUM_W-1:0]          sum;

   assign in_ready = !valid_ff || out_ready;

   assign hund_y = gdq_pkg::YEAR_W'(in_data.qy) * gdq_pkg::YEAR_W'(100);
   assign leap   = (in_data.year[1:0] == 2'd0)
                && ((in_data.year != hund_y) || (in_data.qy[1:0] == 2'd0));

   assign mlen    = gdq_pkg::month_len(in_data.month, leap);
   assign invalid = (mlen == '0) || (in_data.day == '0) || (in_data.day > mlen);

   assign doy  = gdq_pkg::days_before(in_data.month)
               + gdq_pkg::TOYEAR_W'(in_data.day)
               + gdq_pkg::TOYEAR_W'(leap && (in_data.month > gdq_pkg::MONTH_FEB));
   assign ylen = leap ? 9'd366 : 9'd365;

   assign sum = gdq_pkg::SUM_W'(in_data.day) + in_data.yy + (in_data.yy >> 2)
              - gdq_pkg::SUM_W'(in_data.qyy) + gdq_pkg::SUM_W'(in_data.qyy >> 2)
              + gdq_pkg::SUM_W'(gdq_pkg::month_offset(in_data.month));

   always_comb begin
      data_in          = data_ff;
      data_in.sum      = sum;
      data_in.leap     = leap;
      data_in.invalid  = invalid;
      data_in.to_month = invalid ? '0 : mlen - in_data.day + 5'd1;
      data_in.to_year  = invalid ? '0 : ylen - doy + 9'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hw/rtl/gdq_mod7.sv
// ----------------------------------------------------------------------------
// gdq_mod7
// third and fourth stages: reciprocal multiply for the divide by 7, then the
// remainder, weekday flags and the result register
// ----------------------------------------------------------------------------
module gdq_mod7 (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gdq_pkg::s2_type      in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gdq_pkg::res_type     out_data
);

   logic                               c_valid_ff;
   logic                               c_ready;
   gdq_pkg::s3_type                    c_data_ff;
   gdq_pkg::s3_type                    c_data_in;
   logic [gdq_pkg::PROD_S_W-1:0]       prod_s;
   logic                               d_valid_ff;
   logic                               d_ready;
   gdq_pkg::res_type                   d_data_ff;
   gdq_pkg::res_type                   d_data_in;
   logic [gdq_pkg::SUM_W-1:0]          sev_q;
   logic [gdq_pkg::WDAY_W-1:0]         wd;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   assign prod_s = gdq_pkg::PROD_S_W'(in_data.sum) * gdq_pkg::PROD_S_W'(gdq_pkg::RECIP_7);

   always_comb begin
      c_data_in          = c_data_ff;
      c_data_in.sum      = in_data.sum;
      c_data_in.q7       = prod_s[gdq_pkg::SHIFT_7 +: gdq_pkg::Q7_W];
      c_data_in.leap     = in_data.leap;
      c_data_in.invalid  = in_data.invalid;
      c_data_in.to_month = in_data.to_month;
      c_data_in.to_year  = in_data.to_year;
   end

   assign sev_q = gdq_pkg::SUM_W'(c_data_ff.q7) * gdq_pkg::SUM_W'(7);
   assign wd    = c_data_ff.invalid ? '0 : gdq_pkg::WDAY_W'(c_data_ff.sum - sev_q);

   always_comb begin
      d_data_in                   = d_data_ff;
      d_data_in.weekday           = wd;
      d_data_in.is_weekend        = !c_data_ff.invalid && ((wd == 3'd5) || (wd == 3'd6));
      d_data_in.is_week_last_day  = !c_data_ff.invalid && (wd == 3'd6);
      d_data_in.days_to_week_end  = c_data_ff.invalid ? '0 : 3'd6 - wd;
      d_data_in.days_to_month_end = c_data_ff.to_month;
      d_data_in.days_to_year_end  = c_data_ff.to_year;
      d_data_in.leap_year         = c_data_ff.leap;
      d_data_in.date_invalid      = c_data_ff.invalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (c_ready) begin
            c_valid_ff <= in_valid;
         end
         if (d_ready) begin
            d_valid_ff <= c_valid_ff;
         end
      end
      if (c_ready && in_valid) begin
         c_data_ff <= c_data_in;
      end
      if (d_ready && c_valid_ff) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

### hw/rtl/gregorian_date_query.sv
// ----------------------------------------------------------------------------
// gregorian_date_query
// day of week, weekend flags, days to week, month and year end and leap year
// for one gregorian date per beat
// ----------------------------------------------------------------------------
// takes one date beat per clock while req_tready is high and returns one
// result beat per date, in order; the four register stages are the input
// stage with the divide-by-100 reciprocal multiplies, the calendar sums,
// the divide-by-7 reciprocal multiply and the result register. the
// pipeline holds up to four beats; a full stage stalls only while the
// stage after it cannot take its beat. a month outside 1 to 12 or a day
// outside the month sets date_invalid and zeroes every field except
// leap_year.
module gregorian_date_query (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // year_in[13:0], month_in[17:14], day_in[22:18], zero pad
   input  logic [gdq_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // weekday[2:0], is_weekend[3], is_week_last_day[4], days_to_week_end[7:5],
   // days_to_month_end[12:8], days_to_year_end[21:13], leap_year[22],
   // date_invalid[23]
   output logic [gdq_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic                  s1_valid;
   logic                  s1_ready;
   gdq_pkg::s1_type       s1_data;
   logic                  s2_valid;
   logic                  s2_ready;
   gdq_pkg::s2_type       s2_data;
   gdq_pkg::res_type      res;

   gdq_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .year      (req_tdata[13:0]),
      .month     (req_tdata[17:14]),
      .day       (req_tdata[22:18]),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   gdq_cal u_cal (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   gdq_mod7 u_mod7 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   assign rsp_tdata = res;

   a_week_end_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !res.date_invalid) |->
         (res.weekday + res.days_to_week_end == 3'd6))
      else $error("weekday and days to week end disagree");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res.date_invalid) |->
         (res.weekday == '0 && res.days_to_month_end == '0
          && res.days_to_year_end == '0 && !res.is_weekend))
      else $error("invalid date with nonzero fields");

   a_counts_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !res.date_invalid) |->
         (res.days_to_month_end != '0
          && res.days_to_year_end >= 9'(res.days_to_month_end)))
      else $error("month end count out of order with year end count");

   a_last_is_weekend: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res.is_week_last_day) |-> res.is_weekend)
      else $error("saturday not flagged as weekend");

endmodule
